FILE: hdl/sliding_window_rate_limiter_defines.svh
// Assertion macros for the rate limiter controller.
`ifndef SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SWRL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swrl: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SWRL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swrl: next-cycle check failed");

`endif

FILE: hdl/swrl_pkg.sv
// Package for the sliding window rate limiter: widths, register codes, command types.
`timescale 1ns / 1ps

package swrl_pkg;

	// Fixed field widths
	localparam int LEN_W = 32;
	localparam int SUM_W = 38;

	// Parameter defaults
	localparam int DEF_LOG_DEPTH = 64;
	localparam int DEF_TIME_BITS = 48;

	// Window length after reset (one second at microsecond ticks)
	localparam logic [63:0] WINDOW_RESET = 64'd1000000;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture the accepted message
		logic pop;     // retire the oldest log entry
		logic decide;  // make the decision and fill the result register
	} swrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic expired; // oldest log entry lies before the window
	} swrl_stat_t;

endpackage

FILE: hdl/sliding_window_rate_limiter.sv
// Top level of the sliding window rate limiter.
`timescale 1ns / 1ps

// Decides per message whether it is forwarded. With byte_mode 0 a message passes
// when more than period_ticks have elapsed since the last passed one; with
// byte_mode 1 log entries older than now_time - window_ticks are retired, then the
// message passes (and is logged) when the window bytes are below byte_budget and
// the LOG_DEPTH-entry ring has room, else it is dropped (log_full marks a drop for
// a full ring). A message is loaded; in byte mode the single read port of the log
// memory then retires its expired entries one per cycle, and the decision waits
// until the result register is free. A new message is taken while the previous
// result still waits for its output transfer. The log memory needs no clearing
// after reset. Configuration writes are always ready and take effect in the next
// cycle; write them only while no message is in flight.
module sliding_window_rate_limiter
	import swrl_pkg::*;
#(
	parameter int LOG_DEPTH = DEF_LOG_DEPTH,
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [((TIME_BITS > LEN_W) ? TIME_BITS : LEN_W)-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [TIME_BITS-1:0]     now_time,
	input  logic [LEN_W-1:0]         msg_length,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     pass,
	output logic                     log_full,
	output logic [SUM_W-1:0]         window_bytes
);

	swrl_cmd_t  cmd;
	swrl_stat_t stat;

	// Configuration transfers are never stalled
	assign cfg_ready = 1'b1;

	swrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	swrl_dp #(
		.LOG_DEPTH (LOG_DEPTH),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.now_time     (now_time),
		.msg_length   (msg_length),
		.cmd          (cmd),
		.stat         (stat),
		.pass         (pass),
		.log_full     (log_full),
		.window_bytes (window_bytes)
	);

endmodule

FILE: hdl/swrl_ctrl.sv
// Controller for the rate limiter: sequences load, expiry pops and the decision.
`timescale 1ns / 1ps

module swrl_ctrl
	import swrl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  swrl_stat_t stat,
	output swrl_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WORK = 1'b1;

	logic state_q;
	logic state_nxt;
	logic out_valid_q;
	logic in_xfer;
	logic out_free;

	// Handshake
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Commands: pop while the head is stale, then decide once the result slot is free
	always_comb begin
		cmd.load   = in_xfer;
		cmd.pop    = (state_q == ST_WORK) && stat.expired;
		cmd.decide = (state_q == ST_WORK) && !stat.expired && out_free;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_nxt = ST_WORK;
				end
			end
			ST_WORK: begin
				if (cmd.decide) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Result valid: set by a decision, cleared by the output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.decide) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`include "sliding_window_rate_limiter_defines.svh"

	`SWRL_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.decide, !out_valid_q || out_ready)
	`SWRL_ASSERT_IMP(a_pop_xor_decide, clk, arst_n, cmd.pop, !cmd.decide && !in_ready)
	`SWRL_ASSERT_NXT(a_decide_shows, clk, arst_n, cmd.decide, out_valid && in_ready)

endmodule

FILE: hdl/swrl_dp.sv
// Datapath for the rate limiter: config registers, window log ring, running sum, decision.
`timescale 1ns / 1ps

module swrl_dp
	import swrl_pkg::*;
#(
	parameter int LOG_DEPTH = DEF_LOG_DEPTH,
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [((TIME_BITS > LEN_W) ? TIME_BITS : LEN_W)-1:0] cfg_data,
	input  logic [TIME_BITS-1:0]     now_time,
	input  logic [LEN_W-1:0]         msg_length,
	input  swrl_cmd_t                cmd,
	output swrl_stat_t               stat,
	output logic                     pass,
	output logic                     log_full,
	output logic [SUM_W-1:0]         window_bytes
);

	localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CNT_W = $clog2(LOG_DEPTH + 1);
	localparam int ENT_W = TIME_BITS + LEN_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LOG_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LOG_DEPTH);

	// Configuration registers
	logic                 byte_mode_q;
	logic [TIME_BITS-1:0] period_q;
	logic [LEN_W-1:0]     budget_q;
	logic [TIME_BITS-1:0] window_q;

	// Captured message
	logic [TIME_BITS-1:0] now_q;
	logic [LEN_W-1:0]     len_q;
	logic [TIME_BITS-1:0] limit_q;
	logic                 under_q;

	// Log state
	logic [PTR_W-1:0]     head_q;
	logic [PTR_W-1:0]     tail_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [TIME_BITS-1:0] last_pass_q;

	// Log memory
	logic [ENT_W-1:0]     log_mem [LOG_DEPTH];
	logic [ENT_W-1:0]     rd_q;
	logic [PTR_W-1:0]     rd_addr;
	logic [PTR_W-1:0]     head_nxt;
	logic [PTR_W-1:0]     tail_nxt;
	logic [TIME_BITS-1:0] rd_time;
	logic [LEN_W-1:0]     rd_len;

	// Decision terms
	logic [TIME_BITS-1:0] elapsed;
	logic                 msg_ok;
	logic                 budget_ok;
	logic                 ring_full;
	logic                 push;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_mode_q <= 1'b0;
			period_q    <= '0;
			budget_q    <= '0;
			window_q    <= WINDOW_RESET[TIME_BITS-1:0];
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BYTE_MODE:    byte_mode_q <= cfg_data[0];
				REG_PERIOD_TICKS: period_q    <= cfg_data[TIME_BITS-1:0];
				REG_BYTE_BUDGET:  budget_q    <= cfg_data[LEN_W-1:0];
				REG_WINDOW_TICKS: window_q    <= cfg_data[TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Capture the message and its expiry limit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q   <= now_time;
			len_q   <= msg_length;
			limit_q <= now_time - window_q;
			under_q <= (now_time < window_q);
		end
	end

	// Ring pointers
	assign head_nxt = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;

	// Read address tracks the head one step ahead while popping
	assign rd_addr = cmd.pop ? head_nxt : head_q;
	assign rd_time = rd_q[TIME_BITS-1:0];
	assign rd_len  = rd_q[ENT_W-1:TIME_BITS];

	always_ff @(posedge clk) begin
		if (push) begin
			log_mem[tail_q] <= {len_q, now_q};
		end
		rd_q <= log_mem[rd_addr];
	end

	// Oldest entry strictly before now minus window
	assign stat.expired = byte_mode_q && (count_q != '0) && !under_q && (rd_time < limit_q);

	// Decision
	assign elapsed   = now_q - last_pass_q;
	assign msg_ok    = (now_q > last_pass_q) && (elapsed > period_q);
	assign budget_ok = sum_q < {{(SUM_W-LEN_W){1'b0}}, budget_q};
	assign ring_full = (count_q == CNT_FULL);
	assign push      = cmd.decide && byte_mode_q && budget_ok && !ring_full;

	// Log bookkeeping and last pass time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			last_pass_q <= '0;
		end else begin
			if (cmd.pop) begin
				head_q  <= head_nxt;
				count_q <= count_q - 1'b1;
				sum_q   <= sum_q - {{(SUM_W-LEN_W){1'b0}}, rd_len};
			end else if (push) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + {{(SUM_W-LEN_W){1'b0}}, len_q};
			end
			if (cmd.decide && !byte_mode_q && msg_ok) begin
				last_pass_q <= now_q;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			pass         <= byte_mode_q ? (budget_ok && !ring_full) : msg_ok;
			log_full     <= byte_mode_q && budget_ok && ring_full;
			window_bytes <= byte_mode_q ? sum_q : '0;
		end
	end

endmodule

FILE: bench/sliding_window_rate_limiter_tb.sv
// Self-checking testbench for the sliding window rate limiter: directed cases around random phases.
`timescale 1ns / 1ps

typedef logic [swrl_pkg::DEF_TIME_BITS-1:0] tick_t;
typedef logic [swrl_pkg::LEN_W-1:0]         len_t;

// One decision as the block reports it
typedef struct packed {
	logic                     pass;
	logic                     log_full;
	logic [swrl_pkg::SUM_W-1:0] window_bytes;
} limiter_verdict_t;

// Mirror of the limiter state; predicts each decision and holds it until the block answers
class limiter_mirror;
	bit                         byte_mode;
	tick_t                      period_ticks;
	len_t                       byte_budget;
	tick_t                      window_ticks;
	tick_t                      entry_time [swrl_pkg::DEF_LOG_DEPTH];
	len_t                       entry_len  [swrl_pkg::DEF_LOG_DEPTH];
	int                         oldest;
	int                         occupied;
	logic [swrl_pkg::SUM_W-1:0] bytes_in_window;
	tick_t                      last_pass_time;
	limiter_verdict_t           pending_verdicts[$];
	int                         mismatches;

	function new();
		byte_mode       = 1'b0;
		period_ticks    = '0;
		byte_budget     = '0;
		window_ticks    = tick_t'(swrl_pkg::WINDOW_RESET);
		oldest          = 0;
		occupied        = 0;
		bytes_in_window = '0;
		last_pass_time  = '0;
		mismatches      = 0;
	endfunction

	function void set_register(logic [swrl_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
		case (idx)
			swrl_pkg::REG_BYTE_MODE:    byte_mode    = data[0];
			swrl_pkg::REG_PERIOD_TICKS: period_ticks = tick_t'(data);
			swrl_pkg::REG_BYTE_BUDGET:  byte_budget  = len_t'(data);
			swrl_pkg::REG_WINDOW_TICKS: window_ticks = tick_t'(data);
			default: ;
		endcase
	endfunction

	// Decide one accepted message and queue the expected verdict
	function void admit_message(tick_t now, len_t len);
		limiter_verdict_t v;
		tick_t            cutoff;
		int               slot;
		v = '0;
		if (!byte_mode) begin
			// elapsed must be strictly above the period; backwards time never passes
			if (now > last_pass_time && (now - last_pass_time) > period_ticks) begin
				v.pass         = 1'b1;
				last_pass_time = now;
			end
		end else begin
			// retire entries strictly older than the window start
			if (now >= window_ticks) begin
				cutoff = now - window_ticks;
				while (occupied > 0 && entry_time[oldest] < cutoff) begin
					bytes_in_window = bytes_in_window - entry_len[oldest];
					oldest          = (oldest + 1) % swrl_pkg::DEF_LOG_DEPTH;
					occupied--;
				end
			end
			v.window_bytes = bytes_in_window;
			if (bytes_in_window < byte_budget) begin
				if (occupied >= swrl_pkg::DEF_LOG_DEPTH) begin
					v.log_full = 1'b1;
				end else begin
					slot             = (oldest + occupied) % swrl_pkg::DEF_LOG_DEPTH;
					entry_time[slot] = now;
					entry_len[slot]  = len;
					occupied++;
					bytes_in_window  = bytes_in_window + len;
					v.pass           = 1'b1;
				end
			end
		end
		pending_verdicts.insert(pending_verdicts.size(), v);
	endfunction

	task flag_mismatch(string what);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Compare one result transfer with the oldest expected verdict
	task check_verdict(logic p, logic f, logic [swrl_pkg::SUM_W-1:0] w);
		limiter_verdict_t want;
		if (pending_verdicts.size() == 0) begin
			flag_mismatch($sformatf("result with nothing pending: pass=%0b log_full=%0b bytes=%0d",
				p, f, w));
			return;
		end
		want = pending_verdicts[0];
		pending_verdicts.delete(0);
		if (p !== want.pass)
			flag_mismatch($sformatf("pass %0b, expected %0b", p, want.pass));
		if (f !== want.log_full)
			flag_mismatch($sformatf("log_full %0b, expected %0b", f, want.log_full));
		if (w !== want.window_bytes)
			flag_mismatch($sformatf("window_bytes %0d, expected %0d", w, want.window_bytes));
	endtask
endclass

module sliding_window_rate_limiter_tb;
	import swrl_pkg::*;

	localparam int    CFG_W    = (DEF_TIME_BITS > LEN_W) ? DEF_TIME_BITS : LEN_W;
	localparam tick_t TIME_MAX = '1;
	localparam len_t  LEN_MAX  = '1;
	localparam int    MSG_GOAL = 1100;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	tick_t                now_time;
	len_t                 msg_length;
	logic                 out_valid;
	logic                 out_ready;
	logic                 pass;
	logic                 log_full;
	logic [SUM_W-1:0]     window_bytes;

	limiter_mirror mirror;
	tick_t         tick;
	int            sent;
	int            in_quiet;
	int            out_quiet;
	int            out_stall;

	sliding_window_rate_limiter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.now_time     (now_time),
		.msg_length   (msg_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pass         (pass),
		.log_full     (log_full),
		.window_bytes (window_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none, some short, a few long, with quiet stretches of no idling
	function automatic int idle_gap(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic tick_t advance(tick_t t, tick_t d);
		return (TIME_MAX - t < d) ? TIME_MAX : t + d;
	endfunction

	function automatic len_t pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 300);
		if (r < 85)
			return $urandom_range(0, 5000);
		return $urandom;
	endfunction

	// Configuration write transfer
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		mirror.set_register(idx, 64'(data));
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Message transfer; valid stays up into the next call when no gap follows
	task automatic send_message(input tick_t t, input len_t len);
		int g;
		g = idle_gap(in_quiet);
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid   = 1'b1;
		now_time   = t;
		msg_length = len;
		do @(posedge clk); while (!in_ready);
		mirror.admit_message(t, len);
		sent++;
		@(negedge clk);
	endtask

	// Let every pending decision come back before touching the registers
	task automatic settle();
		in_valid = 1'b0;
		while (mirror.pending_verdicts.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Result side: random backpressure
	initial begin
		int g;
		out_ready = 1'b0;
		out_stall = 0;
		out_quiet = 0;
		forever begin
			@(negedge clk);
			if (out_stall > 0) begin
				out_ready = 1'b0;
				out_stall--;
			end else begin
				g = idle_gap(out_quiet);
				out_ready = (g == 0);
				if (g > 0)
					out_stall = g - 1;
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			mirror.check_verdict(pass, log_full, window_bytes);
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Stimulus
	initial begin
		int    n;
		int    r;
		int    span;
		bit    byte_sel;
		tick_t period;
		tick_t window;
		len_t  budget;
		tick_t d;
		mirror     = new();
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_BYTE_MODE;
		cfg_data   = '0;
		in_valid   = 1'b0;
		now_time   = '0;
		msg_length = '0;
		sent       = 0;
		in_quiet   = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Message mode at reset values: equal and backwards times drop
		send_message(48'd0, 32'd0);
		send_message(48'd5, LEN_MAX);
		send_message(48'd5, 32'd1);
		send_message(48'd3, 32'd2);
		settle();
		program_reg(REG_PERIOD_TICKS, CFG_W'(10));
		send_message(48'd15, 32'd7);
		send_message(48'd16, 32'd7);
		settle();
		program_reg(REG_PERIOD_TICKS, CFG_W'(TIME_MAX));
		send_message(48'd1000, 32'd9);
		settle();
		program_reg(REG_PERIOD_TICKS, CFG_W'(0));

		// Byte mode: zero budget, full budget, budget reached
		program_reg(REG_BYTE_MODE, CFG_W'(1));
		send_message(48'd2000, 32'd5);
		settle();
		program_reg(REG_BYTE_BUDGET, CFG_W'(LEN_MAX));
		send_message(48'd2000, LEN_MAX);
		send_message(48'd2001, 32'd10);
		settle();
		program_reg(REG_BYTE_BUDGET, CFG_W'(100));
		send_message(48'd2002, 32'd1);
		settle();

		// Zero window: entries at exactly the cutoff stay, older ones go
		program_reg(REG_WINDOW_TICKS, CFG_W'(0));
		send_message(48'd2002, 32'd3);
		send_message(48'd2002, 32'd4);
		send_message(48'd2003, 32'd5);
		settle();

		// Window longer than time so far: nothing expires
		program_reg(REG_WINDOW_TICKS, CFG_W'(TIME_MAX));
		send_message(48'd5000, 32'd6);
		settle();

		// Back to message mode; last pass time kept across the switch
		program_reg(REG_BYTE_MODE, CFG_W'(0));
		send_message(48'd20, 32'd1);
		send_message(48'd21, 32'd1);
		settle();

		// Random phases, byte mode favored
		tick = 48'd10000;
		while (sent < MSG_GOAL) begin
			settle();
			byte_sel = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 7) == 0)
				tick = advance(tick, tick_t'({$urandom, $urandom}) >> $urandom_range(10, 22));

			r = $urandom_range(0, 5);
			period = (r == 0) ? '0 : (r == 1) ? TIME_MAX : tick_t'($urandom_range(1, 200));
			r = $urandom_range(0, 5);
			window = (r == 0) ? '0 : (r == 1) ? TIME_MAX :
				(r == 2) ? tick_t'(WINDOW_RESET) : tick_t'($urandom_range(20, 3000));
			r = $urandom_range(0, 5);
			budget = (r == 0) ? '0 : (r == 1) ? LEN_MAX :
				(r == 2) ? len_t'($urandom_range(1, 500)) : len_t'($urandom_range(500, 20000));

			program_reg(REG_PERIOD_TICKS, CFG_W'(period));
			program_reg(REG_WINDOW_TICKS, CFG_W'(window));
			program_reg(REG_BYTE_BUDGET, CFG_W'(budget));
			program_reg(REG_BYTE_MODE, CFG_W'(byte_sel));

			if (byte_sel)
				span = (window > 80000) ? 5000 : int'(window / 16) + 1;
			else
				span = (period > 2000) ? 5000 : int'(period) * 2 + 2;

			n = $urandom_range(20, 90);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					// same timestamp again
				end else if (r < 85) begin
					tick = advance(tick, tick_t'($urandom_range(1, span)));
				end else if (r < 95) begin
					tick = advance(tick, tick_t'($urandom_range(span, span * 8)));
				end else begin
					d    = tick_t'($urandom_range(1, span));
					tick = (tick > d) ? tick - d : '0;
				end
				send_message(tick, pick_length());
			end
		end

		// Top of the time range, both modes
		settle();
		program_reg(REG_BYTE_MODE, CFG_W'(0));
		program_reg(REG_PERIOD_TICKS, CFG_W'(3));
		tick = TIME_MAX - 40;
		repeat (12) begin
			tick = advance(tick, tick_t'($urandom_range(0, 8)));
			send_message(tick, $urandom);
		end
		send_message(TIME_MAX, $urandom);
		settle();
		program_reg(REG_WINDOW_TICKS, CFG_W'(100));
		program_reg(REG_BYTE_BUDGET, CFG_W'(LEN_MAX));
		program_reg(REG_BYTE_MODE, CFG_W'(1));
		tick = TIME_MAX - 300;
		repeat (12) begin
			tick = advance(tick, tick_t'($urandom_range(0, 60)));
			send_message(tick, pick_length());
		end
		send_message(TIME_MAX, LEN_MAX);

		// Drain and report
		in_valid = 1'b0;
		while (mirror.pending_verdicts.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mirror.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/swrl_pkg.sv
hdl/swrl_ctrl.sv
hdl/swrl_dp.sv
hdl/sliding_window_rate_limiter.sv
bench/sliding_window_rate_limiter_tb.sv
